// File: rtl/core/odt_pkg.sv
// ============================================================================
// odt_pkg
// Shared types and constants for the odometry distance trigger.
// ============================================================================
`default_nettype none

package odt_pkg;

   // Field widths
   localparam int POS_W   = 32;               // signed pose coordinate
   localparam int DIFF_W  = 31;               // magnitude of a saturated difference
   localparam int SQ_W    = 2 * DIFF_W;       // square of one magnitude
   localparam int RAD_W   = 2 * (DIFF_W + 1); // radicand, even width for 2-bit digits
   localparam int ROOT_W  = RAD_W / 2;        // integer square root
   localparam int TOTAL_W = 33;               // running distance
   localparam int IVL_W   = 32;               // interval register

   localparam logic [IVL_W-1:0] INTERVAL_RESET = 32'd5120;

   // Largest magnitude a coordinate difference may take
   localparam logic [POS_W:0] DIFF_MAX = 33'h0_7FFF_FFFF;
   localparam logic [POS_W:0] DIFF_MIN = 33'h1_8000_0001;

   // Largest running total
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   // Request kinds
   typedef enum logic [0:0] {
      OP_SAMPLE = 1'b0,
      OP_HALT   = 1'b1
   } op_type;

   // Result status
   typedef enum logic [0:0] {
      STS_RUNNING = 1'b0,
      STS_REACHED = 1'b1
   } sts_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SQ_START,
      ST_SQUARE,
      ST_ROOT_START,
      ST_ROOT,
      ST_ACCUM,
      ST_CHECK,
      ST_EMIT
   } st_type;

endpackage

`default_nettype wire

// File: rtl/core/odt_square.sv
// ============================================================================
// odt_square
// Bit-serial shift-add squarer: one multiplier bit per cycle.
// ============================================================================
`default_nettype none

module odt_square
   import odt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIFF_W-1:0] operand,
   output logic                   done,
   output logic                   busy,
   output logic [SQ_W-1:0]        square
);

   localparam int CNT_W = $clog2(DIFF_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIFF_W - 1);

   logic [DIFF_W-1:0] mcand_ff;
   logic [SQ_W-1:0]   prod_ff,  prod_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic [DIFF_W:0]   part_sum;

   // Add the multiplicand into the upper half when the low bit is set, then shift
   always_comb begin
      part_sum = {1'b0, prod_ff[SQ_W-1:DIFF_W]}
               + (prod_ff[0] ? {1'b0, mcand_ff} : {(DIFF_W+1){1'b0}});
      prod_in  = {part_sum, prod_ff[DIFF_W-1:1]};
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Product shift register
   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= operand;
         prod_ff  <= {{DIFF_W{1'b0}}, operand};
      end else if (run_ff) begin
         prod_ff  <= prod_in;
      end
   end

   assign done   = done_ff;
   assign busy   = run_ff;
   assign square = prod_ff;

endmodule

`default_nettype wire

// File: rtl/core/odt_isqrt.sv
// ============================================================================
// odt_isqrt
// Digit-serial integer square root: two radicand bits and one root bit a cycle.
// ============================================================================
`default_nettype none

module odt_isqrt
   import odt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [RAD_W-1:0]  radicand,
   output logic                   done,
   output logic [ROOT_W-1:0]      root
);

   localparam int REM_W = ROOT_W + 2;
   localparam int CNT_W = $clog2(ROOT_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic              run_ff;
   logic              done_ff;
   logic [REM_W+1:0]  shifted;
   logic [REM_W+1:0]  trial;
   logic [REM_W+1:0]  diff;

   // Bring down the next digit pair and try the next root bit
   always_comb begin
      shifted = {rem_ff, rad_ff[RAD_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      diff    = shifted - trial;
      if (shifted >= trial) begin
         rem_in  = diff[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = shifted[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], 1'b0};
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Radicand, remainder and root shift registers
   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (run_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

// File: rtl/core/odometry_distance_trigger_core.sv
// ============================================================================
// odometry_distance_trigger_core
// Accumulates planar travel from pose samples and flags each distance interval.
// ============================================================================
// Each beat on req carries a pose (x, y in 1/1024 m) or a halt. A halt, or the
// first pose after reset or halt, goes from decode straight to the emit state.
// A later pose squares both saturated coordinate deltas in two bit-serial
// squarers, then takes a digit-serial square root of the sum, adds it to the
// total and compares against interval_length. One item is in work at a time.
// A finished result sits in the rsp output register, so the next beat may be
// taken while it waits. The user must write interval_length through csr only
// while the block is idle; the block itself does not enforce it. The status flag
// is set when the total reaches interval_length, and the total then restarts
// from zero.
`default_nettype none

module odometry_distance_trigger_core
   import odt_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // pose requests
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [63:0]        req_tdata,   // [31:0] pos_x, [63:32] pos_y
   input  wire logic [0:0]         req_tuser,   // [0] opcode
   // results
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [39:0]             rsp_tdata,   // [32:0] distance_so_far, rest zero
   output logic [0:0]              rsp_tuser,   // [0] status
   // configuration
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [IVL_W-1:0]   csr_wdata    // interval_length
);

   // Sequencer
   st_type state_ff, state_in;

   // Architectural state
   logic [IVL_W-1:0]   interval_ff;
   logic [POS_W-1:0]   prev_x_ff, prev_y_ff;
   logic               have_prev_ff;
   logic [TOTAL_W-1:0] travelled_ff;

   // Latched request
   op_type             op_ff;
   logic [POS_W-1:0]   pos_x_ff, pos_y_ff;

   // Datapath
   logic [POS_W:0]     dx_ff, dy_ff;
   logic [POS_W:0]     dx_raw, dy_raw, dx_sat, dy_sat;
   logic [DIFF_W-1:0]  dx_mag, dy_mag;
   logic [RAD_W-1:0]   rad_ff;
   logic [TOTAL_W-1:0] sum_ff;
   logic [TOTAL_W:0]   sum_wide;

   // Pending result and output register
   sts_type            res_sts_ff;
   logic [TOTAL_W-1:0] res_dist_ff;
   logic               rsp_valid_ff;
   sts_type            rsp_sts_ff;
   logic [TOTAL_W-1:0] rsp_dist_ff;

   // Serial units
   logic               sq_start, root_start;
   logic               sqx_done, sqy_done, sqx_busy, sqy_busy;
   logic [SQ_W-1:0]    sqx, sqy;
   logic               root_done;
   logic [ROOT_W-1:0]  root;
   logic               out_free;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   // Saturated coordinate differences
   always_comb begin
      dx_raw = {pos_x_ff[POS_W-1], pos_x_ff} - {prev_x_ff[POS_W-1], prev_x_ff};
      dy_raw = {pos_y_ff[POS_W-1], pos_y_ff} - {prev_y_ff[POS_W-1], prev_y_ff};
      dx_sat = dx_raw;
      dy_sat = dy_raw;
      if (!dx_raw[POS_W] && dx_raw > DIFF_MAX) dx_sat = DIFF_MAX;
      if (dx_raw[POS_W] && dx_raw < DIFF_MIN)  dx_sat = DIFF_MIN;
      if (!dy_raw[POS_W] && dy_raw > DIFF_MAX) dy_sat = DIFF_MAX;
      if (dy_raw[POS_W] && dy_raw < DIFF_MIN)  dy_sat = DIFF_MIN;
   end

   // Magnitudes fed to the squarers
   always_comb begin
      logic [POS_W:0] ax, ay;
      ax = dx_ff[POS_W] ? (~dx_ff + 1'b1) : dx_ff;
      ay = dy_ff[POS_W] ? (~dy_ff + 1'b1) : dy_ff;
      dx_mag = ax[DIFF_W-1:0];
      dy_mag = ay[DIFF_W-1:0];
   end

   // Saturating accumulate
   assign sum_wide = {1'b0, travelled_ff} + {{(TOTAL_W + 1 - ROOT_W){1'b0}}, root};

   odt_square u_sq_x (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (dx_mag),
      .done    (sqx_done),
      .busy    (sqx_busy),
      .square  (sqx)
   );

   odt_square u_sq_y (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (dy_mag),
      .done    (sqy_done),
      .busy    (sqy_busy),
      .square  (sqy)
   );

   odt_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (rad_ff),
      .done     (root_done),
      .root     (root)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_tvalid) state_in = ST_DECODE;
         ST_DECODE: begin
            if (op_ff == OP_HALT || !have_prev_ff) state_in = ST_EMIT;
            else                                   state_in = ST_SQ_START;
         end
         ST_SQ_START:   state_in = ST_SQUARE;
         ST_SQUARE:     if (sqx_done) state_in = ST_ROOT_START;
         ST_ROOT_START: state_in = ST_ROOT;
         ST_ROOT:       if (root_done) state_in = ST_ACCUM;
         ST_ACCUM:      state_in = ST_CHECK;
         ST_CHECK:      state_in = ST_EMIT;
         ST_EMIT:       if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      sq_start   = 1'b0;
      root_start = 1'b0;
      unique case (state_ff)
         ST_IDLE:       req_tready = 1'b1;
         ST_SQ_START:   sq_start   = 1'b1;
         ST_ROOT_START: root_start = 1'b1;
         default: begin
         end
      endcase
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         interval_ff  <= INTERVAL_RESET;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         travelled_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) interval_ff <= csr_wdata;

         // halt and first pose settle here
         if (state_ff == ST_DECODE) begin
            if (op_ff == OP_HALT) begin
               have_prev_ff <= 1'b0;
               travelled_ff <= '0;
            end else if (!have_prev_ff) begin
               prev_x_ff    <= pos_x_ff;
               prev_y_ff    <= pos_y_ff;
               have_prev_ff <= 1'b1;
            end
         end

         // pose becomes the reference once the step is measured
         if (state_ff == ST_ACCUM) begin
            prev_x_ff <= pos_x_ff;
            prev_y_ff <= pos_y_ff;
         end

         if (state_ff == ST_CHECK) begin
            if (sum_ff < {1'b0, interval_ff}) travelled_ff <= sum_ff;
            else                              travelled_ff <= '0;
         end

         // output register
         if (state_ff == ST_EMIT && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_tready)                 rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         op_ff    <= op_type'(req_tuser[0]);
         pos_x_ff <= req_tdata[POS_W-1:0];
         pos_y_ff <= req_tdata[2*POS_W-1:POS_W];
      end
      if (state_ff == ST_DECODE) begin
         dx_ff       <= dx_sat;
         dy_ff       <= dy_sat;
         res_sts_ff  <= STS_RUNNING;
         res_dist_ff <= (op_ff == OP_HALT) ? '0 : travelled_ff;
      end
      if (state_ff == ST_SQUARE && sqx_done) begin
         rad_ff <= {1'b0, {1'b0, sqx} + {1'b0, sqy}};
      end
      if (state_ff == ST_ACCUM) begin
         sum_ff <= sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
      end
      if (state_ff == ST_CHECK) begin
         if (sum_ff < {1'b0, interval_ff}) begin
            res_sts_ff  <= STS_RUNNING;
            res_dist_ff <= sum_ff;
         end else begin
            res_sts_ff  <= STS_REACHED;
            res_dist_ff <= '0;
         end
      end
      if (state_ff == ST_EMIT && out_free) begin
         rsp_sts_ff  <= res_sts_ff;
         rsp_dist_ff <= res_dist_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(40 - TOTAL_W){1'b0}}, rsp_dist_ff};
   assign rsp_tuser  = rsp_sts_ff;

   // The two squarer lanes run in lockstep
   a_sq_lockstep: assert property (@(posedge clock) disable iff (reset)
      (sqx_done == sqy_done) && (sqx_busy == sqy_busy))
      else $error("squarer lanes out of step");

   // A root only completes while the sequencer waits for it
   a_root_owner: assert property (@(posedge clock) disable iff (reset)
      root_done |-> state_ff == ST_ROOT)
      else $error("square root finished outside its state");

   // A success result always reports a cleared distance
   a_success_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_sts_ff == STS_REACHED) |-> rsp_dist_ff == '0)
      else $error("success result with nonzero distance");

   // Squarers are quiet whenever the sequencer waits for a beat
   a_no_sq_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !sqx_busy)
      else $error("squarer running while idle");

endmodule

`default_nettype wire

// File: bench/tb_odometry_distance_trigger_core.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_odometry_distance_trigger_core
// Self-checking bench for the odometry distance trigger core.
// ============================================================================
// A short directed table covers the halt, the first pose after reset or halt,
// an exact interval hit, zero steps, saturated coordinate deltas and the
// interval extremes. A random walk then runs under several interval settings.
// Every pose beat is run through a local model of the trip total, and each
// result beat is checked field by field against the oldest pending prediction.
// Both sides idle at random. The interval is only rewritten once all results
// are back.

module tb_odometry_distance_trigger_core
   import odt_pkg::*;
();

   localparam int     WATCHDOG_LIMIT = 3000;  // cycles with no beat on any channel
   localparam int     SETTLE_CYCLES  = 80;    // a bit over the longest pose latency
   localparam int     RANDOM_PHASES  = 7;
   localparam int     PHASE_ITEMS    = 200;
   localparam longint SAT_LIMIT      = 64'sd2147483647;

   typedef struct packed {
      sts_type              status;
      logic [TOTAL_W-1:0]   distance;
   } trip_report_type;

   typedef enum logic {
      ROW_CFG,
      ROW_POSE
   } row_kind_type;

   // One line of the directed plan; x carries the interval on a CFG row
   typedef struct {
      row_kind_type         kind;
      op_type               op;
      logic [31:0]          x;
      logic [31:0]          y;
      logic                 pinned;
      sts_type              want_sts;
      logic [TOTAL_W-1:0]   want_dist;
   } plan_row_type;

   // DUT signals
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [63:0]          req_tdata = '0;   // [31:0] pos_x, [63:32] pos_y
   logic [0:0]           req_tuser = '0;   // [0] opcode
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [39:0]          rsp_tdata;        // [32:0] distance_so_far
   logic [0:0]           rsp_tuser;        // [0] status
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [IVL_W-1:0]     csr_wdata = '0;

   // Typed-in expectation that rides along with a directed beat
   logic                 pin_on   = 1'b0;
   sts_type              pin_sts  = STS_RUNNING;
   logic [TOTAL_W-1:0]   pin_dist = '0;

   // Model state of the trip
   logic [IVL_W-1:0]     trip_interval = INTERVAL_RESET;
   logic [31:0]          last_x = '0;
   logic [31:0]          last_y = '0;
   logic                 pose_held = 1'b0;
   logic [TOTAL_W-1:0]   trip_total = '0;

   trip_report_type      trip_q[$];
   plan_row_type         plan[$];
   int                   poses_sent = 0;
   int                   reports_seen = 0;
   int                   mismatch_count = 0;
   int                   quiet_cycles = 0;
   int                   sink_hold = 0;
   logic                 sink_eager = 1'b0;
   int                   sink_cycle = 0;

   odometry_distance_trigger_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Trip model
   // ------------------------------------------------------------------

   // Magnitude of a coordinate delta, clamped to 2^31-1
   function automatic longint delta_mag(logic [31:0] now_pos, logic [31:0] was_pos);
      longint d;
      d = longint'($signed(now_pos)) - longint'($signed(was_pos));
      if (d > SAT_LIMIT) d = SAT_LIMIT;
      if (d < -SAT_LIMIT) d = -SAT_LIMIT;
      return (d < 0) ? -d : d;
   endfunction

   // Floor of the square root, one bit per pass from the top
   function automatic logic [31:0] floor_root(logic [63:0] v);
      logic [63:0] cand;
      logic [31:0] root;
      root = '0;
      for (int i = 31; i >= 0; i--) begin
         cand = {32'd0, root | (32'd1 << i)};
         if (cand * cand <= v) root = root | (32'd1 << i);
      end
      return root;
   endfunction

   // Advances the trip by one beat and returns the report it should produce
   function automatic trip_report_type advance_trip(op_type op, logic [31:0] x,
                                                    logic [31:0] y);
      trip_report_type  rep;
      longint           mx;
      longint           my;
      logic [31:0]      hop;
      logic [TOTAL_W:0] sum;
      rep.status   = STS_RUNNING;
      rep.distance = '0;
      if (op == OP_HALT) begin
         pose_held  = 1'b0;
         trip_total = '0;
         return rep;
      end
      // first pose only sets the reference
      if (!pose_held) begin
         last_x       = x;
         last_y       = y;
         pose_held    = 1'b1;
         rep.distance = trip_total;
         return rep;
      end
      mx     = delta_mag(x, last_x);
      my     = delta_mag(y, last_y);
      hop    = floor_root(64'(mx * mx + my * my));
      last_x = x;
      last_y = y;
      sum    = {1'b0, trip_total} + hop;
      trip_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      if (trip_total < {1'b0, trip_interval}) begin
         rep.distance = trip_total;
      end else begin
         trip_total = '0;
         rep.status = STS_REACHED;
      end
      return rep;
   endfunction

   // ------------------------------------------------------------------
   // Monitor: model update, result check, watchdog
   // ------------------------------------------------------------------
   task automatic note_miss(string what, logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin
      trip_report_type want_r;
      trip_report_type got_r;
      if (!reset) begin
         if (csr_valid && csr_ready) trip_interval = csr_wdata;
         if (req_tvalid && req_tready) begin
            want_r = advance_trip(op_type'(req_tuser[0]), req_tdata[31:0], req_tdata[63:32]);
            if (pin_on) want_r = {pin_sts, pin_dist};
            trip_q.push_back(want_r);
         end
         if (rsp_tvalid && rsp_tready) begin
            reports_seen++;
            got_r = {sts_type'(rsp_tuser[0]), rsp_tdata[TOTAL_W-1:0]};
            if (trip_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("[%0t] result beat with nothing pending: status %0d distance %0d",
                           $realtime, got_r.status, got_r.distance);
            end else begin
               want_r = trip_q.pop_front();
               if (got_r.status != want_r.status)
                  note_miss("status", TOTAL_W'(want_r.status), TOTAL_W'(got_r.status));
               if (got_r.distance != want_r.distance)
                  note_miss("distance_so_far", want_r.distance, got_r.distance);
            end
         end
         // watchdog on any beat
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("odometry_distance_trigger_core test failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result sink: random stalls, with stretches of none
   // ------------------------------------------------------------------
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      sink_cycle <= sink_cycle + 1;
      if (sink_cycle % 300 == 0) sink_eager <= ($urandom_range(0, 3) == 0);
      if (sink_hold != 0) begin
         rsp_tready <= 1'b0;
         sink_hold  <= sink_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!sink_eager && $urandom_range(0, 99) < 30) sink_hold <= idle_span();
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Presents one pose beat and waits until it is taken; valid stays high
   task automatic send_pose(op_type op, logic [31:0] x, logic [31:0] y, logic pinned,
                            sts_type ws, logic [TOTAL_W-1:0] wd);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {y, x};
      pin_on     <= pinned;
      pin_sts    <= ws;
      pin_dist   <= wd;
      do @(posedge clock); while (!req_tready);
      poses_sent++;
   endtask

   task automatic rest(int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Holds off until every result has come back
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (reports_seen < poses_sent) @(posedge clock);
   endtask

   task automatic write_interval(logic [IVL_W-1:0] v);
      wait_quiet();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [IVL_W-1:0] ivl;
      logic [31:0]      walk_x;
      logic [31:0]      walk_y;
      logic [31:0]      px;
      logic [31:0]      py;
      op_type           op;
      int               scale;
      int               r;
      logic             steady;

      // directed plan
      plan.push_back('{ROW_POSE, OP_HALT,   32'd0,    32'd0,    1'b1, STS_RUNNING, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'd0,    32'd0,    1'b1, STS_RUNNING, 33'd0});
      // 3-4-5 triangle lands exactly on the reset interval
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'd3072, 32'd4096, 1'b1, STS_REACHED, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'd3072, 32'd4096, 1'b1, STS_RUNNING, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'd3075, 32'd4100, 1'b1, STS_RUNNING, 33'd5});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                       1'b1, STS_REACHED, 33'd0});
      // both deltas saturate
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'h8000_0000, 32'h8000_0000,
                       1'b1, STS_REACHED, 33'd0});
      plan.push_back('{ROW_POSE, OP_HALT,   32'd123,  32'd456,  1'b1, STS_RUNNING, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF,
                       1'b1, STS_RUNNING, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000,
                       1'b1, STS_REACHED, 33'd0});
      // largest interval: two saturated hops are needed
      plan.push_back('{ROW_CFG,  OP_SAMPLE, 32'hFFFF_FFFF, 32'd0, 1'b0, STS_RUNNING, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF,
                       1'b0, STS_RUNNING, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000,
                       1'b1, STS_REACHED, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       1'b0, STS_RUNNING, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       1'b0, STS_RUNNING, 33'd0});
      // smallest interval: a zero step still fires on a nonzero total
      plan.push_back('{ROW_CFG,  OP_SAMPLE, 32'd1,    32'd0,    1'b0, STS_RUNNING, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                       1'b0, STS_RUNNING, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'd0, 32'hFFFF_FFFF, 1'b1, STS_REACHED, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'd0, 32'hFFFF_FFFF, 1'b1, STS_RUNNING, 33'd0});
      plan.push_back('{ROW_POSE, OP_HALT,   32'hFFFF_FFFF, 32'd0, 1'b1, STS_RUNNING, 33'd0});
      plan.push_back('{ROW_CFG,  OP_SAMPLE, 32'd5120, 32'd0,    1'b0, STS_RUNNING, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'd1000, 32'd0,    1'b1, STS_RUNNING, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'd1000, 32'd5119, 1'b1, STS_RUNNING, 33'd5119});
      plan.push_back('{ROW_POSE, OP_SAMPLE, 32'd1001, 32'd5119, 1'b1, STS_REACHED, 33'd0});
      plan.push_back('{ROW_POSE, OP_SAMPLE, -32'sd1000, -32'sd1000,
                       1'b0, STS_RUNNING, 33'd0});

      // reset
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CFG) begin
            write_interval(plan[i].x);
         end else begin
            send_pose(plan[i].op, plan[i].x, plan[i].y, plan[i].pinned,
                      plan[i].want_sts, plan[i].want_dist);
            rest(idle_span());
         end
      end

      // random walk under several intervals
      walk_x = $urandom();
      walk_y = $urandom();
      steady = 1'b0;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       ivl = INTERVAL_RESET;
            1:       ivl = $urandom_range(2, 64);
            2:       ivl = $urandom_range(1000, 50000);
            3:       ivl = $urandom();
            4:       ivl = 32'hFFFF_FFFF;
            5:       ivl = 32'd1;
            default: ivl = $urandom_range(100, 10000);
         endcase
         if (ivl == 0) ivl = 32'd1;
         write_interval(ivl);
         scale = (ivl / 3 > 32'h0100_0000) ? 32'h0100_0000 : int'(ivl / 3);
         if (scale < 4) scale = 4;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 50 == 0) steady = ($urandom_range(0, 3) == 0);
            r  = $urandom_range(0, 99);
            op = OP_SAMPLE;
            if (r < 5) begin
               op = OP_HALT;
            end else if (r < 15) begin
               walk_x = $urandom();
               walk_y = $urandom();
            end else if (r >= 20) begin
               walk_x = walk_x + ($urandom_range(0, 2 * scale) - scale);
               walk_y = walk_y + ($urandom_range(0, 2 * scale) - scale);
            end
            px = (op == OP_HALT) ? $urandom() : walk_x;
            py = (op == OP_HALT) ? $urandom() : walk_y;
            send_pose(op, px, py, 1'b0, STS_RUNNING, '0);
            if ($urandom_range(0, 199) == 0)
               wait_quiet();
            else
               rest(steady ? 0 : idle_span());
         end
      end

      // drain and settle
      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (trip_q.size() != 0) begin
         mismatch_count++;
         $display("%0d expected results never arrived", trip_q.size());
      end
      if (mismatch_count == 0)
         $display("odometry_distance_trigger_core test passed");
      else
         $display("odometry_distance_trigger_core test failed");
      $finish;
   end

endmodule
